### src/llrs_pkg.sv
`timescale 1ns / 1ps

package llrs_pkg;

  localparam int CMD_W  = 2;
  localparam int SLOT_W = 4;
  localparam int LOAD_W = 16;
  localparam int STAT_W = 2;
  localparam int ADV_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_SELECT = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [ADV_W-1:0] {
    ADV_NONE    = 2'd0,
    ADV_HIGH    = 2'd1,
    ADV_NOMINAL = 2'd2
  } adv_e;

  typedef struct packed {
    cmd_e cmd;
    logic in_range;
  } cls_t;

  localparam int CLS_W = $bits(cls_t);

endpackage

### src/llrs_ram.sv
`timescale 1ns / 1ps

module llrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/llrs_fifo.sv
`timescale 1ns / 1ps

module llrs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### src/llrs_front.sv
`timescale 1ns / 1ps

module llrs_front #(
  parameter int NUM_SLOTS = 16,
  parameter int LOAD_BITS = 16
) (
  input  logic                         start,
  input  logic [llrs_pkg::CMD_W-1:0]   command_i,
  input  logic [llrs_pkg::SLOT_W-1:0]  slot_i,
  input  logic [llrs_pkg::LOAD_W-1:0]  load_i,
  input  logic                         full_i,
  output logic                         busy,
  output logic                         push_o,
  output llrs_pkg::cls_t               cls_o,
  output logic [$clog2(NUM_SLOTS)-1:0] idx_o,
  output logic [LOAD_BITS-1:0]         load_o
);

  localparam int IDX_W = $clog2(NUM_SLOTS);

  logic [IDX_W+llrs_pkg::SLOT_W-1:0]     slot_ext;
  logic [LOAD_BITS+llrs_pkg::LOAD_W-1:0] load_ext;
  logic                                  in_range;

  assign slot_ext = (IDX_W + llrs_pkg::SLOT_W)'(slot_i);
  assign load_ext = (LOAD_BITS + llrs_pkg::LOAD_W)'(load_i);
  assign in_range = (32'(slot_i) < 32'(NUM_SLOTS));

  assign busy           = full_i;
  assign push_o         = start && !full_i;
  assign cls_o.cmd      = llrs_pkg::cmd_e'(command_i);
  assign cls_o.in_range = in_range;
  assign idx_o          = in_range ? slot_ext[IDX_W-1:0] : '0;
  assign load_o         = load_ext[LOAD_BITS-1:0];

endmodule

### src/llrs_back.sv
`timescale 1ns / 1ps

module llrs_back #(
  parameter int NUM_SLOTS = 16,
  parameter int LOAD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  llrs_pkg::cls_t                cls_i,
  input  logic [$clog2(NUM_SLOTS)-1:0]  idx_i,
  input  logic [LOAD_BITS-1:0]          load_i,
  output logic                          pop_o,
  output logic                          valid_o,
  output logic [llrs_pkg::STAT_W-1:0]   status_o,
  output logic [llrs_pkg::SLOT_W-1:0]   chosen_slot_o,
  output logic [llrs_pkg::ADV_W-1:0]    advisory_o
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CW    = $clog2(NUM_SLOTS + 1);
  localparam int SW    = LOAD_BITS + CW;
  localparam int NNW   = 2 * CW;
  localparam int PW    = LOAD_BITS + 2 * CW + 4;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_MUL0  = 3'd4;
  localparam logic [2:0] S_MUL1  = 3'd5;
  localparam logic [2:0] S_JUDGE = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [NUM_SLOTS-1:0] valid_q, valid_d, flag_q, flag_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d, ridx_q, idx_q, idx_d;
  logic                 rd_pend_q, rd_pend_d;
  llrs_pkg::cmd_e       cmd_q, cmd_d;
  logic [LOAD_BITS-1:0] c_q, c_d, best_q, best_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic                 found_q, found_d;
  logic [CW-1:0]        n_q, n_d;
  logic [SW-1:0]        s_q, s_d;
  logic [NNW-1:0]       nn_q, nn_d;
  logic [CW:0]          n1_q, n1_d;
  logic [CW+3:0]        n9_q, n9_d;
  logic [PW-1:0]        pc_q, pc_d, ps1_q, ps1_d, ps9_q, ps9_d, pc10;

  logic                 res_valid_q, res_valid_d;
  llrs_pkg::status_e    status_q, status_d;
  llrs_pkg::adv_e       adv_q, adv_d;
  logic [IDX_W-1:0]     chosen_q, chosen_d;
  logic [IDX_W+llrs_pkg::SLOT_W-1:0] chosen_ext;

  logic                 ram_we;
  logic [LOAD_BITS-1:0] ram_rdata;

  llrs_ram #(
    .WIDTH(LOAD_BITS),
    .DEPTH(NUM_SLOTS)
  ) u_load_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_i),
    .wdata_i(load_i),
    .raddr_i(cnt_q),
    .rdata_o(ram_rdata)
  );

  assign pop_o = (state_q == S_IDLE) && !empty_i;
  assign pc10  = (pc_q << 3) + (pc_q << 1);

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    flag_d      = flag_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    rd_pend_d   = 1'b0;
    cmd_d       = cmd_q;
    c_d         = c_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    found_d     = found_q;
    n_d         = n_q;
    s_d         = s_q;
    nn_d        = nn_q;
    n1_d        = n1_q;
    n9_d        = n9_q;
    pc_d        = pc_q;
    ps1_d       = ps1_q;
    ps9_d       = ps9_q;
    res_valid_d = 1'b0;
    status_d    = status_q;
    adv_d       = adv_q;
    chosen_d    = chosen_q;
    ram_we      = 1'b0;

    if (rd_pend_q && valid_q[ridx_q]) begin
      n_d = n_q + 1'b1;
      s_d = s_q + SW'(ram_rdata);
      if (!found_q || (ram_rdata < best_q)) begin
        found_d    = 1'b1;
        best_d     = ram_rdata;
        best_idx_d = ridx_q;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          status_d = llrs_pkg::ST_OK;
          adv_d    = llrs_pkg::ADV_NONE;
          chosen_d = '0;
          cmd_d    = cls_i.cmd;
          idx_d    = idx_i;
          c_d      = load_i;
          cnt_d    = '0;
          n_d      = '0;
          s_d      = '0;
          found_d  = 1'b0;
          case (cls_i.cmd)
            llrs_pkg::CMD_INSERT: begin
              res_valid_d = 1'b1;
              if (!cls_i.in_range) begin
                status_d = llrs_pkg::ST_ABSENT;
              end else if (valid_q[idx_i]) begin
                status_d = llrs_pkg::ST_PRESENT;
              end else begin
                ram_we         = 1'b1;
                valid_d[idx_i] = 1'b1;
                flag_d[idx_i]  = 1'b0;
              end
            end
            llrs_pkg::CMD_REMOVE: begin
              res_valid_d = 1'b1;
              if (!cls_i.in_range || !valid_q[idx_i]) begin
                status_d = llrs_pkg::ST_ABSENT;
              end else begin
                valid_d[idx_i] = 1'b0;
                flag_d[idx_i]  = 1'b0;
              end
            end
            llrs_pkg::CMD_UPDATE: begin
              if (!cls_i.in_range || !valid_q[idx_i]) begin
                res_valid_d = 1'b1;
                status_d    = llrs_pkg::ST_ABSENT;
              end else begin
                ram_we  = 1'b1;
                state_d = S_WALK;
              end
            end
            default: begin
              state_d = S_WALK;
            end
          endcase
        end
      end
      S_WALK: begin
        rd_pend_d = 1'b1;
        if (cnt_q == IDX_W'(NUM_SLOTS - 1)) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = (cmd_q == llrs_pkg::CMD_SELECT) ? S_EMIT : S_MUL0;
      end
      S_EMIT: begin
        res_valid_d = 1'b1;
        if (found_q) begin
          chosen_d = best_idx_q;
        end else begin
          status_d = llrs_pkg::ST_EMPTY;
        end
        state_d = S_IDLE;
      end
      S_MUL0: begin
        nn_d    = NNW'(n_q) * NNW'(n_q);
        n1_d    = (CW + 1)'(n_q) + 1'b1;
        n9_d    = ((CW + 4)'(n_q) << 3) + ((CW + 4)'(n_q) << 1) + (CW + 4)'(9);
        state_d = S_MUL1;
      end
      S_MUL1: begin
        pc_d    = PW'(c_q) * PW'(nn_q);
        ps1_d   = PW'(s_q) * PW'(n1_q);
        ps9_d   = PW'(s_q) * PW'(n9_q);
        state_d = S_JUDGE;
      end
      S_JUDGE: begin
        res_valid_d = 1'b1;
        if (s_q != '0) begin
          if (pc_q > ps1_q) begin
            flag_d[idx_q] = 1'b1;
            adv_d         = llrs_pkg::ADV_HIGH;
          end else if (flag_q[idx_q] && (pc10 < ps9_q)) begin
            flag_d[idx_q] = 1'b0;
            adv_d         = llrs_pkg::ADV_NOMINAL;
          end
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      flag_q      <= '0;
      rd_pend_q   <= 1'b0;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      flag_q      <= flag_d;
      rd_pend_q   <= rd_pend_d;
      res_valid_q <= res_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q     <= cnt_q;
    idx_q      <= idx_d;
    cmd_q      <= cmd_d;
    c_q        <= c_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    found_q    <= found_d;
    n_q        <= n_d;
    s_q        <= s_d;
    nn_q       <= nn_d;
    n1_q       <= n1_d;
    n9_q       <= n9_d;
    pc_q       <= pc_d;
    ps1_q      <= ps1_d;
    ps9_q      <= ps9_d;
    status_q   <= status_d;
    adv_q      <= adv_d;
    chosen_q   <= chosen_d;
  end

  assign chosen_ext    = (IDX_W + llrs_pkg::SLOT_W)'(chosen_q);
  assign valid_o       = res_valid_q;
  assign status_o      = status_q;
  assign chosen_slot_o = chosen_ext[llrs_pkg::SLOT_W-1:0];
  assign advisory_o    = adv_q;

endmodule

### src/least_loaded_replica_selector.sv
`timescale 1ns / 1ps
// Insert, remove and rejected updates are answered from the idle state. A select walks
// the load RAM (one slot per cycle) and then emits; a load update walks the RAM and then
// runs the multiply/compare steps before its result appears on valid_o.
// Throughput: one item per cycle for insert and remove while busy is low; a select or
// update holds the back end until its result. A two-entry queue fronts it, busy = full.
// Results pulse valid_o once, no stall; async reset clears valid marks, flags, queue, control.

module least_loaded_replica_selector #(
  parameter int NUM_SLOTS = 16,
  parameter int LOAD_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [llrs_pkg::CMD_W-1:0]  command_i,
  input  logic [llrs_pkg::SLOT_W-1:0] slot_i,
  input  logic [llrs_pkg::LOAD_W-1:0] load_i,
  output logic                        busy,
  output logic                        valid_o,
  output logic [llrs_pkg::STAT_W-1:0] status_o,
  output logic [llrs_pkg::SLOT_W-1:0] chosen_slot_o,
  output logic [llrs_pkg::ADV_W-1:0]  advisory_o
);

  localparam int IDX_W   = $clog2(NUM_SLOTS);
  localparam int Q_W     = llrs_pkg::CLS_W + IDX_W + LOAD_BITS;
  localparam int Q_DEPTH = 2;

  llrs_pkg::cls_t       f_cls, b_cls;
  logic [IDX_W-1:0]     f_idx, b_idx;
  logic [LOAD_BITS-1:0] f_load, b_load;
  logic                 push, pop, q_empty, q_full;
  logic [Q_W-1:0]       q_rdata;

  llrs_front #(
    .NUM_SLOTS(NUM_SLOTS),
    .LOAD_BITS(LOAD_BITS)
  ) u_front (
    .start    (start),
    .command_i(command_i),
    .slot_i   (slot_i),
    .load_i   (load_i),
    .full_i   (q_full),
    .busy     (busy),
    .push_o   (push),
    .cls_o    (f_cls),
    .idx_o    (f_idx),
    .load_o   (f_load)
  );

  llrs_fifo #(
    .WIDTH(Q_W),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({f_cls, f_idx, f_load}),
    .pop_i  (pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  assign {b_cls, b_idx, b_load} = q_rdata;

  llrs_back #(
    .NUM_SLOTS(NUM_SLOTS),
    .LOAD_BITS(LOAD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .cls_i        (b_cls),
    .idx_i        (b_idx),
    .load_i       (b_load),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .chosen_slot_o(chosen_slot_o),
    .advisory_o   (advisory_o)
  );

endmodule
